@@ hdl/bbc_pkg.sv @@
package bbc_pkg;

    localparam int SAMPLE_BITS = 18;
    localparam int FRAC_BITS = 16;
    localparam int COEF_FRAC_BITS = 30;
    localparam int STATE_BITS = 40;
    localparam int OUT_BITS = 20;
    localparam int SPLIT_BITS = 20;
    localparam int COEF_BITS = 32;
    localparam int HALF_BITS = STATE_BITS - SPLIT_BITS + 1;
    localparam int PROD_BITS = COEF_BITS + HALF_BITS;
    localparam int ACC_BITS = 56;
    localparam int TAPS = 5;
    localparam int STEPS = 2 * TAPS;
    localparam int STEP_BITS = $clog2(STEPS);

    localparam logic SECT_HP = 1'b0;
    localparam logic SECT_LP = 1'b1;

    localparam logic [2:0] TAP_X0 = 3'd0;
    localparam logic [2:0] TAP_X1 = 3'd1;
    localparam logic [2:0] TAP_X2 = 3'd2;
    localparam logic [2:0] TAP_Y1 = 3'd3;
    localparam logic [2:0] TAP_Y2 = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_COMB,
        ST_WRITE,
        ST_OUT
    } bbc_state_t;

    typedef struct packed {
        logic clear;
        logic issue;
        logic half;
        logic combine;
    } bbc_mac_ctl_t;

    typedef struct packed {
        logic       accept;
        logic       sect;
        logic [2:0] tap;
        logic       write;
        logic       load_out;
    } bbc_seq_t;

    // Feedback coefficients are stored negated, so every tap is a plain add.
    function automatic logic signed [COEF_BITS-1:0] coef_at(input logic sect,
                                                           input logic [2:0] tap);
        logic signed [COEF_BITS-1:0] c;
        c = '0;
        if (sect == SECT_HP) begin
            case (tap)
                TAP_X0: c = 32'sd1067052477;
                TAP_X1: c = -32'sd2134104954;
                TAP_X2: c = 32'sd1067052477;
                TAP_Y1: c = 32'sd2133960729;
                TAP_Y2: c = -32'sd1060507355;
                default: c = '0;
            endcase
        end else begin
            case (tap)
                TAP_X0: c = 32'sd649388;
                TAP_X1: c = 32'sd1298777;
                TAP_X2: c = 32'sd649388;
                TAP_Y1: c = 32'sd2134822729;
                TAP_Y2: c = -32'sd1062614369;
                default: c = '0;
            endcase
        end
        return c;
    endfunction

endpackage

@@ hdl/bbc_mac.sv @@
module bbc_mac
    import bbc_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bbc_mac_ctl_t                  ctl,
    input  logic signed [COEF_BITS-1:0]   coef,
    input  logic signed [STATE_BITS-1:0]  operand,
    output logic signed [STATE_BITS-1:0]  result
);

    localparam int SH_BITS = ACC_BITS - (COEF_FRAC_BITS - SPLIT_BITS);

    logic signed [HALF_BITS-1:0] op_half;
    logic signed [PROD_BITS-1:0] prod_next;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic                        acc_en_reg;
    logic                        acc_half_reg;
    logic signed [ACC_BITS-1:0]  acc_lo_reg, acc_lo_next;
    logic signed [ACC_BITS-1:0]  acc_hi_reg, acc_hi_next;
    logic signed [ACC_BITS-1:0]  prod_ext;
    logic signed [ACC_BITS-1:0]  carry_ext;
    logic signed [SH_BITS-1:0]   shifted;

    // The low half of the operand is unsigned, the high half carries the sign.
    assign op_half = ctl.half
        ? {operand[STATE_BITS-1], operand[STATE_BITS-1:SPLIT_BITS]}
        : {{(HALF_BITS-SPLIT_BITS){1'b0}}, operand[SPLIT_BITS-1:0]};

    assign prod_next = coef * op_half;
    assign prod_ext = {{(ACC_BITS-PROD_BITS){prod_reg[PROD_BITS-1]}}, prod_reg};
    assign carry_ext = {{SPLIT_BITS{acc_lo_reg[ACC_BITS-1]}},
                        acc_lo_reg[ACC_BITS-1:SPLIT_BITS]};

    always_comb begin
        acc_lo_next = acc_lo_reg;
        acc_hi_next = acc_hi_reg;
        if (ctl.clear) begin
            // The rounding half is preloaded into the low accumulator.
            acc_lo_next = ACC_BITS'(1) <<< (COEF_FRAC_BITS - 1);
            acc_hi_next = '0;
        end else if (ctl.combine) begin
            acc_hi_next = acc_hi_reg + carry_ext;
        end else if (acc_en_reg) begin
            if (acc_half_reg) begin
                acc_hi_next = acc_hi_reg + prod_ext;
            end else begin
                acc_lo_next = acc_lo_reg + prod_ext;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_en_reg <= 1'b0;
            acc_half_reg <= 1'b0;
        end else begin
            acc_en_reg <= ctl.issue;
            acc_half_reg <= ctl.half;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_lo_reg <= acc_lo_next;
        acc_hi_reg <= acc_hi_next;
    end

    assign shifted = acc_hi_reg[ACC_BITS-1:COEF_FRAC_BITS-SPLIT_BITS];

    always_comb begin
        if (shifted[SH_BITS-1:STATE_BITS-1] == '0 ||
            shifted[SH_BITS-1:STATE_BITS-1] == '1) begin
            result = shifted[STATE_BITS-1:0];
        end else if (shifted[SH_BITS-1]) begin
            result = {1'b1, {(STATE_BITS-1){1'b0}}};
        end else begin
            result = {1'b0, {(STATE_BITS-1){1'b1}}};
        end
    end

endmodule

@@ hdl/bbc_seq.sv @@
module bbc_seq
    import bbc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    output bbc_mac_ctl_t mac_ctl,
    output bbc_seq_t     seq
);

    bbc_state_t           state_reg, state_next;
    logic [STEP_BITS-1:0] cnt_reg, cnt_next;
    logic                 sect_reg, sect_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        sect_next = sect_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MUL;
                    cnt_next = '0;
                    sect_next = SECT_HP;
                end
            end
            ST_MUL: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_BITS'(STEPS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_COMB;
            ST_COMB: state_next = ST_WRITE;
            ST_WRITE: begin
                if (sect_reg == SECT_HP) begin
                    state_next = ST_MUL;
                    cnt_next = '0;
                    sect_next = SECT_LP;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        seq.accept = (state_reg == ST_IDLE) && s_valid;
        seq.sect = sect_reg;
        seq.tap = cnt_reg[STEP_BITS-1:1];
        seq.write = (state_reg == ST_WRITE);
        seq.load_out = (state_reg == ST_OUT) && out_free;
        mac_ctl.clear = seq.accept || (seq.write && sect_reg == SECT_HP);
        mac_ctl.issue = (state_reg == ST_MUL);
        mac_ctl.half = cnt_reg[0];
        mac_ctl.combine = (state_reg == ST_COMB);
        if (seq.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            sect_reg <= SECT_HP;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            sect_reg <= sect_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ hdl/ppg_bandpass_biquad_cascade.sv @@
// Band-pass filter for an optical pulse sample stream: a high-pass biquad
// followed by a low-pass biquad, both direct form I with fixed coefficients.
// Input channel s_valid/s_ready carries one unsigned sample per item; the
// result channel m_valid/m_ready returns one signed, saturated, band-passed
// sample per item, in order.
// Every product runs through one 32x21 multiplier: each of the five taps of
// a section is split into two 20-bit halves, so a section issues ten
// products, then passes through a drain, a rounding combine and a write-back.
// m_valid rises in the same cycle that s_ready returns, so the block takes a
// new sample only once the last one has reached the output register.
// The result sits in an output register; if the receiver stalls, the block
// holds the next finished item until that register is free and accepts
// nothing meanwhile. Stalls never drop or repeat items.
// A synchronous reset (aresetn low) clears all filter history to zero, so
// the first samples see zero history, and leaves the block idle and ready.
module ppg_bandpass_biquad_cascade
    import bbc_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [SAMPLE_BITS-1:0]      s_sample,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [OUT_BITS-1:0]  m_filtered
);

    localparam int INT_BITS = STATE_BITS - FRAC_BITS;
    localparam int PAD_BITS = STATE_BITS - SAMPLE_BITS - FRAC_BITS;

    bbc_mac_ctl_t                mac_ctl;
    bbc_seq_t                    seq;
    logic signed [COEF_BITS-1:0] coef;
    logic signed [STATE_BITS-1:0] operand;
    logic signed [STATE_BITS-1:0] result;

    logic [SAMPLE_BITS-1:0]      x_reg;
    logic [SAMPLE_BITS-1:0]      hp_in_prev1_reg, hp_in_prev2_reg;
    logic signed [STATE_BITS-1:0] hp_out_prev1_reg, hp_out_prev2_reg;
    logic signed [STATE_BITS-1:0] lp_in_prev1_reg, lp_in_prev2_reg;
    logic signed [STATE_BITS-1:0] lp_out_prev1_reg, lp_out_prev2_reg;
    logic signed [OUT_BITS-1:0]  filtered_reg, filtered_next;
    logic signed [INT_BITS-1:0]  lp_int;

    bbc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .mac_ctl (mac_ctl),
        .seq     (seq)
    );

    bbc_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .coef    (coef),
        .operand (operand),
        .result  (result)
    );

    assign coef = coef_at(seq.sect, seq.tap);

    always_comb begin
        operand = '0;
        if (seq.sect == SECT_HP) begin
            case (seq.tap)
                TAP_X0: operand = {{PAD_BITS{1'b0}}, x_reg, {FRAC_BITS{1'b0}}};
                TAP_X1: operand = {{PAD_BITS{1'b0}}, hp_in_prev1_reg, {FRAC_BITS{1'b0}}};
                TAP_X2: operand = {{PAD_BITS{1'b0}}, hp_in_prev2_reg, {FRAC_BITS{1'b0}}};
                TAP_Y1: operand = hp_out_prev1_reg;
                TAP_Y2: operand = hp_out_prev2_reg;
                default: operand = '0;
            endcase
        end else begin
            // The high-pass output of this item was just written to hp_out_prev1.
            case (seq.tap)
                TAP_X0: operand = hp_out_prev1_reg;
                TAP_X1: operand = lp_in_prev1_reg;
                TAP_X2: operand = lp_in_prev2_reg;
                TAP_Y1: operand = lp_out_prev1_reg;
                TAP_Y2: operand = lp_out_prev2_reg;
                default: operand = '0;
            endcase
        end
    end

    assign lp_int = lp_out_prev1_reg[STATE_BITS-1:FRAC_BITS];

    always_comb begin
        if (lp_int[INT_BITS-1:OUT_BITS-1] == '0 || lp_int[INT_BITS-1:OUT_BITS-1] == '1) begin
            filtered_next = lp_int[OUT_BITS-1:0];
        end else if (lp_int[INT_BITS-1]) begin
            filtered_next = {1'b1, {(OUT_BITS-1){1'b0}}};
        end else begin
            filtered_next = {1'b0, {(OUT_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hp_in_prev1_reg <= '0;
            hp_in_prev2_reg <= '0;
            hp_out_prev1_reg <= '0;
            hp_out_prev2_reg <= '0;
            lp_in_prev1_reg <= '0;
            lp_in_prev2_reg <= '0;
            lp_out_prev1_reg <= '0;
            lp_out_prev2_reg <= '0;
        end else if (seq.write) begin
            if (seq.sect == SECT_HP) begin
                hp_in_prev2_reg <= hp_in_prev1_reg;
                hp_in_prev1_reg <= x_reg;
                hp_out_prev2_reg <= hp_out_prev1_reg;
                hp_out_prev1_reg <= result;
            end else begin
                lp_in_prev2_reg <= lp_in_prev1_reg;
                lp_in_prev1_reg <= hp_out_prev1_reg;
                lp_out_prev2_reg <= lp_out_prev1_reg;
                lp_out_prev1_reg <= result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (seq.accept) begin
            x_reg <= s_sample;
        end
        if (seq.load_out) begin
            filtered_reg <= filtered_next;
        end
    end

    assign m_filtered = filtered_reg;

endmodule

@@ bench/bandpass_checker.sv @@
module bandpass_checker
    import bbc_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [SAMPLE_BITS-1:0]      s_sample,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic signed [OUT_BITS-1:0]  m_filtered,
    output int                          fail_count,
    output int                          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDE_BITS = 96;
    localparam logic signed [WIDE_BITS-1:0] STATE_HI =
        (96'sd1 <<< (STATE_BITS - 1)) - 96'sd1;
    localparam logic signed [WIDE_BITS-1:0] STATE_LO = -STATE_HI - 96'sd1;
    localparam logic signed [STATE_BITS-1:0] OUT_HI =
        (40'sd1 <<< (OUT_BITS - 1)) - 40'sd1;
    localparam logic signed [STATE_BITS-1:0] OUT_LO = -OUT_HI - 40'sd1;

    // Filter history, mirrored from the block's point of view.
    logic [SAMPLE_BITS-1:0]        hp_x1, hp_x2;
    logic signed [STATE_BITS-1:0]  hp_y1, hp_y2;
    logic signed [STATE_BITS-1:0]  lp_x1, lp_x2;
    logic signed [STATE_BITS-1:0]  lp_y1, lp_y2;

    logic signed [OUT_BITS-1:0]    expected_filtered[$];
    int                            mismatches = 0;

    function automatic logic signed [STATE_BITS-1:0] to_state(
        input logic [SAMPLE_BITS-1:0] x);
        return {{(STATE_BITS - SAMPLE_BITS - FRAC_BITS){1'b0}}, x, {FRAC_BITS{1'b0}}};
    endfunction

    // One direct-form-I section: exact sum of five products, rounded half up
    // on the way back to the state format, then saturated to the state width.
    // Feedback coefficients are held negated so every tap adds.
    function automatic logic signed [STATE_BITS-1:0] biquad_section(
        input logic sect,
        input logic signed [STATE_BITS-1:0] x0, x1, x2, y1, y2);
        longint                        c[5];
        logic signed [STATE_BITS-1:0]  tap[5];
        logic signed [WIDE_BITS-1:0]   wc, wv, acc;
        if (sect == SECT_HP) begin
            c[0] = 64'sd1067052477;
            c[1] = -64'sd2134104954;
            c[2] = 64'sd1067052477;
            c[3] = 64'sd2133960729;
            c[4] = -64'sd1060507355;
        end else begin
            c[0] = 64'sd649388;
            c[1] = 64'sd1298777;
            c[2] = 64'sd649388;
            c[3] = 64'sd2134822729;
            c[4] = -64'sd1062614369;
        end
        tap[0] = x0;
        tap[1] = x1;
        tap[2] = x2;
        tap[3] = y1;
        tap[4] = y2;
        acc = '0;
        for (int i = 0; i < 5; i++) begin
            wc = c[i];
            wv = tap[i];
            acc = acc + wc * wv;
        end
        acc = acc + (96'sd1 <<< (COEF_FRAC_BITS - 1));
        acc = acc >>> COEF_FRAC_BITS;
        if (acc > STATE_HI) acc = STATE_HI;
        else if (acc < STATE_LO) acc = STATE_LO;
        return acc[STATE_BITS-1:0];
    endfunction

    task automatic filter_sample(input logic [SAMPLE_BITS-1:0] x,
                                 output logic signed [OUT_BITS-1:0] y);
        logic signed [STATE_BITS-1:0] hp, lp, whole;
        hp = biquad_section(SECT_HP, to_state(x), to_state(hp_x1), to_state(hp_x2),
                            hp_y1, hp_y2);
        hp_x2 = hp_x1;
        hp_x1 = x;
        hp_y2 = hp_y1;
        hp_y1 = hp;
        lp = biquad_section(SECT_LP, hp, lp_x1, lp_x2, lp_y1, lp_y2);
        lp_x2 = lp_x1;
        lp_x1 = hp;
        lp_y2 = lp_y1;
        lp_y1 = lp;
        whole = lp >>> FRAC_BITS;
        if (whole > OUT_HI) whole = OUT_HI;
        else if (whole < OUT_LO) whole = OUT_LO;
        y = whole[OUT_BITS-1:0];
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] checker: %s", $time, what);
    endtask

    always @(posedge aclk) begin
        logic signed [OUT_BITS-1:0] want;
        if (!aresetn) begin
            hp_x1 = '0;
            hp_x2 = '0;
            hp_y1 = '0;
            hp_y2 = '0;
            lp_x1 = '0;
            lp_x2 = '0;
            lp_y1 = '0;
            lp_y2 = '0;
            expected_filtered.delete();
        end else begin
            // Results leave before the new item enters, so a result is never
            // matched against the item accepted at the same edge.
            if (m_valid && m_ready) begin
                if (expected_filtered.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no item outstanding",
                                              m_filtered));
                end else begin
                    want = expected_filtered.pop_front();
                    if (m_filtered !== want)
                        report_mismatch($sformatf("filtered got %0d, want %0d",
                                                  m_filtered, want));
                end
            end
            if (s_valid && s_ready) begin
                filter_sample(s_sample, want);
                expected_filtered.push_back(want);
            end
        end
        fail_count  <= mismatches;
        outstanding <= expected_filtered.size();
    end

endmodule

@@ bench/tb_top.sv @@
module tb_top;
    import bbc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
    localparam int RANDOM_ITEMS = 1500;
    localparam int HOLD_AFTER   = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 3000;

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic [SAMPLE_BITS-1:0]      s_sample;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [OUT_BITS-1:0]  m_filtered;
    int                          fail_count;
    int                          outstanding;

    bit                          steady_send = 1'b0;
    bit                          steady_recv = 1'b0;
    int                          received = 0;
    int                          idle_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    ppg_bandpass_biquad_cascade u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_filtered (m_filtered)
    );

    bandpass_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_filtered  (m_filtered),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
        int gap;
        gap = steady_send ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Receiver: random stalls per item, calm stretches, and one long hold-off
    // so the block fills and has to stall its input.
    initial begin
        int stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (received % 40 == 0) steady_recv = ($urandom_range(0, 3) == 0);
            if (received == HOLD_AFTER) stall = HOLD_CYCLES;
            else if (steady_recv) stall = 0;
            else stall = $urandom_range(0, 7);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            received++;
        end
    end

    initial begin
        int sent, kind, len, base, amp, period, ph, v;
        aresetn  <= 1'b0;
        s_valid  <= 1'b0;
        s_sample <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero history start-up, full-scale steps both ways,
        // fastest alternation of the extremes, and single-bit, near-full and alternating-bit codes.
        send_sample('0);
        send_sample('0);
        repeat (4) send_sample(SAMPLE_BITS'(SAMPLE_MAX));
        repeat (3) send_sample('0);
        repeat (4) begin
            send_sample(SAMPLE_BITS'(SAMPLE_MAX));
            send_sample('0);
        end
        send_sample(18'd1);
        send_sample(18'h20000);
        send_sample(18'h1ffff);
        send_sample(18'h3fffe);
        send_sample(18'h15555);
        send_sample(18'h2aaaa);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 4);
            len = $urandom_range(20, 80);
            steady_send = ($urandom_range(0, 3) == 0);
            base = $urandom_range(20000, 200000);
            amp = $urandom_range(0, 60000);
            period = $urandom_range(8, 64);
            for (int i = 0; i < len; i++) begin
                case (kind)
                    0: v = $urandom_range(0, SAMPLE_MAX);
                    1: v = base;
                    2: begin
                        ph = i % period;
                        if (ph >= period / 2) ph = period - ph;
                        v = base + (amp * ph * 2) / period;
                    end
                    3: v = (i % 2 == 0) ? SAMPLE_MAX : 0;
                    default: v = base + $urandom_range(0, 64) - 32;
                endcase
                if (v > SAMPLE_MAX) v = SAMPLE_MAX;
                if (v < 0) v = 0;
                send_sample(v[SAMPLE_BITS-1:0]);
                sent++;
            end
        end
        s_valid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/bbc_pkg.sv
hdl/bbc_mac.sv
hdl/bbc_seq.sv
hdl/ppg_bandpass_biquad_cascade.sv
bench/bandpass_checker.sv
bench/tb_top.sv
